// ===== hw/rtl/mzx_pkg.sv =====
`default_nettype none

package mzx_pkg;

  // Output position fields carry the low bits of the coordinates.
  localparam int POS_BITS   = 4;
  localparam int START_BITS = 4;

  typedef enum logic [1:0] {
    DIR_NORTH = 2'd0,
    DIR_EAST  = 2'd1,
    DIR_SOUTH = 2'd2,
    DIR_WEST  = 2'd3
  } mzx_dir_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_OPEN  = 2'd1,
    STATUS_OFF_GRID = 2'd2
  } mzx_status_t;

  typedef enum logic {
    OP_OBSERVE = 1'b0,
    OP_RESTART = 1'b1
  } mzx_op_t;

  typedef enum logic [0:0] {
    REG_START_ROW = 1'b0,
    REG_START_COL = 1'b1
  } mzx_cfg_reg_t;

  typedef struct packed {
    logic op;
    logic wall_north;
    logic wall_east;
    logic wall_south;
    logic wall_west;
  } mzx_item_t;

  typedef struct packed {
    logic [1:0]          direction;
    logic                moved;
    logic [POS_BITS-1:0] pos_row;
    logic [POS_BITS-1:0] pos_col;
    logic                at_center;
    logic [1:0]          status;
  } mzx_result_t;

  // Count store control signals.
  typedef struct packed {
    logic clear;  // restart: forget all counts, start cell reads as one
    logic bump;   // write the incremented count of the cell moved into
  } mzx_store_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/maze_explorer_next_move_unit.sv =====
`default_nettype none

// Maze explorer next-move unit. Takes one item per clock while the skid entry
// is empty; each result is registered. The visit counts of the four cells
// around the current position are read ahead from a four-bank count RAM (two
// read ports per bank, banked by row and column parity) in the same cycle that
// the position is updated, so a decision is one compare pass over four
// registered counts and the rate is set by that loop through the position
// register. A restart clears the map through per-cell valid flags; there is
// no clearing sweep after reset. A two-entry result buffer lets one more item
// be accepted while the result side stalls.
module maze_explorer_next_move_unit #(
  parameter int GRID_SIZE  = 16,
  parameter int COUNT_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_index,
  input  logic [mzx_pkg::START_BITS-1:0]  cfg_data,
  input  logic                            item_valid,
  output logic                            item_stall,
  input  mzx_pkg::mzx_item_t              item,
  output logic                            result_valid,
  input  logic                            result_stall,
  output mzx_pkg::mzx_result_t            result
);
  import mzx_pkg::*;

  localparam int CB     = $clog2(GRID_SIZE);
  localparam int DS     = CB + 2;
  localparam int SQ     = 2 * DS;
  localparam int DSUM   = SQ + 1;
  localparam int TARGET = GRID_SIZE / 2 - 1;

  localparam logic signed [DS-1:0] TARGET_S = DS'(TARGET);

  function automatic logic [SQ-1:0] square(input logic signed [DS-1:0] x);
    logic signed [SQ-1:0] xe;
    xe = SQ'(x);
    return unsigned'(xe * xe);
  endfunction

  logic [START_BITS-1:0] start_row;
  logic [START_BITS-1:0] start_col;
  logic [CB-1:0]         start_row_sat;
  logic [CB-1:0]         start_col_sat;

  logic [CB-1:0]         cur_row;
  logic [CB-1:0]         cur_col;
  logic [CB-1:0]         cur_row_next;
  logic [CB-1:0]         cur_col_next;

  logic                  accept;
  logic                  take;
  logic                  skid_valid;
  mzx_result_t           skid;
  mzx_result_t           res_new;

  mzx_store_ctrl_t       ctrl;
  logic [3:0][COUNT_BITS-1:0] nb_count;
  logic [COUNT_BITS-1:0] bump_count;

  logic [3:0]            open;
  logic [3:0]            off;
  logic [3:0][CB-1:0]    nb_row;
  logic [3:0][CB-1:0]    nb_col;
  logic signed [DS-1:0]  dr0;
  logic signed [DS-1:0]  dc0;
  logic [SQ-1:0]         sq_rm;
  logic [SQ-1:0]         sq_r0;
  logic [SQ-1:0]         sq_rp;
  logic [SQ-1:0]         sq_cm;
  logic [SQ-1:0]         sq_c0;
  logic [SQ-1:0]         sq_cp;
  logic [3:0][DSUM-1:0]  nb_dist;
  logic [3:0][COUNT_BITS-1:0] cnt;
  logic                  found;
  mzx_dir_t              best_dir;
  logic [COUNT_BITS-1:0] best_cnt;
  logic [DSUM-1:0]       best_dist;
  logic                  do_move;
  logic [CB-1:0]         new_row;
  logic [CB-1:0]         new_col;

  assign cfg_ready  = 1'b1;
  assign item_stall = skid_valid;
  assign accept     = item_valid && !item_stall;
  assign take       = result_valid && !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_row <= '0;
      start_col <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_START_ROW: start_row <= cfg_data;
        REG_START_COL: start_col <= cfg_data;
        default: ;
      endcase
    end
  end

  // Decision for the item at the port, from the prefetched neighbor counts.
  always_comb begin
    start_row_sat = (int'(start_row) > GRID_SIZE - 1) ? CB'(GRID_SIZE - 1) : CB'(start_row);
    start_col_sat = (int'(start_col) > GRID_SIZE - 1) ? CB'(GRID_SIZE - 1) : CB'(start_col);

    open = ~{item.wall_west, item.wall_south, item.wall_east, item.wall_north};

    off[DIR_NORTH] = cur_row == '0;
    off[DIR_EAST]  = cur_col == CB'(GRID_SIZE - 1);
    off[DIR_SOUTH] = cur_row == CB'(GRID_SIZE - 1);
    off[DIR_WEST]  = cur_col == '0;

    nb_row[DIR_NORTH] = cur_row - CB'(1);
    nb_col[DIR_NORTH] = cur_col;
    nb_row[DIR_EAST]  = cur_row;
    nb_col[DIR_EAST]  = cur_col + CB'(1);
    nb_row[DIR_SOUTH] = cur_row + CB'(1);
    nb_col[DIR_SOUTH] = cur_col;
    nb_row[DIR_WEST]  = cur_row;
    nb_col[DIR_WEST]  = cur_col - CB'(1);

    // Off-grid neighbors use their virtual coordinates, one past the edge.
    dr0   = signed'(DS'(cur_row)) - TARGET_S;
    dc0   = signed'(DS'(cur_col)) - TARGET_S;
    sq_rm = square(dr0 - DS'(1));
    sq_r0 = square(dr0);
    sq_rp = square(dr0 + DS'(1));
    sq_cm = square(dc0 - DS'(1));
    sq_c0 = square(dc0);
    sq_cp = square(dc0 + DS'(1));
    nb_dist[DIR_NORTH] = DSUM'(sq_rm) + DSUM'(sq_c0);
    nb_dist[DIR_EAST]  = DSUM'(sq_r0) + DSUM'(sq_cp);
    nb_dist[DIR_SOUTH] = DSUM'(sq_rp) + DSUM'(sq_c0);
    nb_dist[DIR_WEST]  = DSUM'(sq_r0) + DSUM'(sq_cm);

    for (int s = 0; s < 4; s++) begin
      cnt[s] = off[s] ? '0 : nb_count[s];
    end

    // Scan in N, E, S, W order; strict compares keep the earlier side on ties.
    found     = 1'b0;
    best_dir  = DIR_NORTH;
    best_cnt  = '0;
    best_dist = '0;
    for (int s = 0; s < 4; s++) begin
      if (open[s] && (!found || cnt[s] < best_cnt ||
                      (cnt[s] == best_cnt && nb_dist[s] < best_dist))) begin
        found     = 1'b1;
        best_dir  = mzx_dir_t'(2'(s));
        best_cnt  = cnt[s];
        best_dist = nb_dist[s];
      end
    end

    bump_count = (best_cnt == '1) ? best_cnt : best_cnt + COUNT_BITS'(1);

    do_move   = 1'b0;
    new_row   = cur_row;
    new_col   = cur_col;
    res_new.direction = DIR_NORTH;
    res_new.moved     = 1'b0;
    res_new.status    = STATUS_OK;
    if (item.op == OP_RESTART) begin
      new_row = start_row_sat;
      new_col = start_col_sat;
    end else if (!found) begin
      res_new.status = STATUS_NO_OPEN;
    end else if (off[best_dir]) begin
      res_new.direction = best_dir;
      res_new.status    = STATUS_OFF_GRID;
    end else begin
      do_move           = 1'b1;
      new_row           = nb_row[best_dir];
      new_col           = nb_col[best_dir];
      res_new.direction = best_dir;
      res_new.moved     = 1'b1;
    end
    res_new.pos_row   = POS_BITS'(new_row);
    res_new.pos_col   = POS_BITS'(new_col);
    res_new.at_center = (new_row == CB'(TARGET) || new_row == CB'(TARGET + 1)) &&
                        (new_col == CB'(TARGET) || new_col == CB'(TARGET + 1));

    cur_row_next = accept ? new_row : cur_row;
    cur_col_next = accept ? new_col : cur_col;
    ctrl.clear   = accept && item.op == OP_RESTART;
    ctrl.bump    = accept && do_move;
  end

  mzx_count_store #(
    .GRID_SIZE  (GRID_SIZE),
    .COUNT_BITS (COUNT_BITS)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .row_next   (cur_row_next),
    .col_next   (cur_col_next),
    .bump_count (bump_count),
    .nb_count   (nb_count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row <= '0;
      cur_col <= '0;
    end else begin
      cur_row <= cur_row_next;
      cur_col <= cur_col_next;
    end
  end

  // Result register plus skid entry; the skid fills only on a stalled transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (accept) begin
      if (result_valid && !take) begin
        skid       <= res_new;
        skid_valid <= 1'b1;
      end else begin
        result       <= res_new;
        result_valid <= 1'b1;
      end
    end else if (skid_valid && (take || !result_valid)) begin
      result       <= skid;
      result_valid <= 1'b1;
      skid_valid   <= 1'b0;
    end else if (take) begin
      result_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_result: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid entry holds data while result register is empty");

  a_restart_pos: assert property (@(posedge clk) disable iff (rst)
    accept && item.op == OP_RESTART |=>
      cur_row == $past(start_row_sat) && cur_col == $past(start_col_sat))
    else $error("restart did not place explorer at start cell");

  a_move_one_step: assert property (@(posedge clk) disable iff (rst)
    accept && do_move |=>
      ((cur_row != $past(cur_row)) != (cur_col != $past(cur_col))))
    else $error("move changed position by other than one side");

  a_hold_no_move: assert property (@(posedge clk) disable iff (rst)
    accept && item.op == OP_OBSERVE && !do_move |=> $stable(cur_row) && $stable(cur_col))
    else $error("position changed without a move");

  a_moved_ok: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.moved |-> result.status == STATUS_OK)
    else $error("moved result carries error status");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/mzx_count_store.sv =====
`default_nettype none

module mzx_count_store #(
  parameter int GRID_SIZE  = 16,
  parameter int COUNT_BITS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  mzx_pkg::mzx_store_ctrl_t             ctrl,
  input  logic [$clog2(GRID_SIZE)-1:0]         row_next,
  input  logic [$clog2(GRID_SIZE)-1:0]         col_next,
  input  logic [COUNT_BITS-1:0]                bump_count,
  output logic [3:0][COUNT_BITS-1:0]           nb_count
);
  import mzx_pkg::*;

  localparam int CB         = $clog2(GRID_SIZE);
  localparam int AB         = 2 * CB;
  localparam int BB         = AB - 2;
  localparam int CELLS      = 1 << AB;
  localparam int BANK_DEPTH = 1 << BB;

  // Four banks by (row parity, column parity): north and south neighbors share
  // one bank, east and west the other, so two read ports per bank suffice.
  logic [COUNT_BITS-1:0] mem [4][BANK_DEPTH];
  logic [COUNT_BITS-1:0] rd_a [4];
  logic [COUNT_BITS-1:0] rd_b [4];
  logic                  rp;
  logic                  cp;

  logic [CELLS-1:0]      valid;
  logic [CB-1:0]         home_row;
  logic [CB-1:0]         home_col;
  logic                  home_fresh;
  logic [CB-1:0]         home_row_next;
  logic [CB-1:0]         home_col_next;
  logic                  home_fresh_next;
  logic [3:0]            nb_valid;
  logic [3:0]            nb_home;

  logic [3:0][CB-1:0]    nb_row;
  logic [3:0][CB-1:0]    nb_col;
  logic [3:0][AB-1:0]    nb_idx;
  logic [3:0][BB-1:0]    nb_addr;
  logic [BB-1:0]         port_a [4];
  logic [BB-1:0]         port_b [4];
  logic [1:0]            wbank;
  logic [BB-1:0]         waddr;
  logic [AB-1:0]         widx;
  logic [3:0][COUNT_BITS-1:0] raw;

  always_comb begin
    nb_row[DIR_NORTH] = row_next - CB'(1);
    nb_col[DIR_NORTH] = col_next;
    nb_row[DIR_EAST]  = row_next;
    nb_col[DIR_EAST]  = col_next + CB'(1);
    nb_row[DIR_SOUTH] = row_next + CB'(1);
    nb_col[DIR_SOUTH] = col_next;
    nb_row[DIR_WEST]  = row_next;
    nb_col[DIR_WEST]  = col_next - CB'(1);
    for (int s = 0; s < 4; s++) begin
      nb_idx[s]  = {nb_row[s], nb_col[s]};
      nb_addr[s] = {nb_row[s][CB-1:1], nb_col[s][CB-1:1]};
    end
    for (int b = 0; b < 4; b++) begin
      if (b[1] != row_next[0]) begin
        port_a[b] = nb_addr[DIR_NORTH];
        port_b[b] = nb_addr[DIR_SOUTH];
      end else begin
        port_a[b] = nb_addr[DIR_EAST];
        port_b[b] = nb_addr[DIR_WEST];
      end
    end
    wbank = {row_next[0], col_next[0]};
    waddr = {row_next[CB-1:1], col_next[CB-1:1]};
    widx  = {row_next, col_next};
  end

  always_comb begin
    home_row_next   = home_row;
    home_col_next   = home_col;
    home_fresh_next = home_fresh;
    if (ctrl.clear) begin
      home_row_next   = row_next;
      home_col_next   = col_next;
      home_fresh_next = 1'b1;
    end else if (ctrl.bump && widx == {home_row, home_col}) begin
      home_fresh_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    for (int b = 0; b < 4; b++) begin
      rd_a[b] <= mem[b][port_a[b]];
      rd_b[b] <= mem[b][port_b[b]];
    end
    if (ctrl.bump) begin
      mem[wbank][waddr] <= bump_count;
    end
    rp <= row_next[0];
    cp <= col_next[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      home_row   <= '0;
      home_col   <= '0;
      home_fresh <= 1'b1;
      nb_valid   <= '0;
      nb_home    <= '0;
    end else begin
      home_row   <= home_row_next;
      home_col   <= home_col_next;
      home_fresh <= home_fresh_next;
      for (int s = 0; s < 4; s++) begin
        nb_valid[s] <= ctrl.clear ? 1'b0 : valid[nb_idx[s]];
        nb_home[s]  <= home_fresh_next && nb_idx[s] == {home_row_next, home_col_next};
      end
      if (ctrl.clear) begin
        valid <= '0;
      end else if (ctrl.bump) begin
        valid[widx] <= 1'b1;
      end
    end
  end

  always_comb begin
    raw[DIR_NORTH] = rd_a[{~rp, cp}];
    raw[DIR_SOUTH] = rd_b[{~rp, cp}];
    raw[DIR_EAST]  = rd_a[{rp, ~cp}];
    raw[DIR_WEST]  = rd_b[{rp, ~cp}];
    for (int s = 0; s < 4; s++) begin
      if (nb_home[s]) begin
        nb_count[s] = COUNT_BITS'(1);
      end else if (nb_valid[s]) begin
        nb_count[s] = raw[s];
      end else begin
        nb_count[s] = '0;
      end
    end
  end

endmodule

`default_nettype wire
